// ===== rtl/core/mfp_pkg.sv =====
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types and constants of the 802.15.4 MAC frame parser: the tag word
// passed from the front end to the back end, and the result word.
// ----------------------------------------------------------------------------
package mfp_pkg;

  // default values of the top level parameters
  localparam int MAX_ROUTE_HOPS_DEF     = 8;
  localparam int MAX_FRAME_LEN_DEF      = 127;
  localparam int TAG_QUEUE_DEPTH_DEF    = 4;
  localparam int RESULT_QUEUE_DEPTH_DEF = 2;

  localparam logic [15:0] ADDR_ABSENT   = 16'hFFFF;
  localparam logic [15:0] ADDR_EXTENDED = 16'hFFFE;

  localparam logic [1:0] KIND_PLAIN  = 2'd0;
  localparam logic [1:0] KIND_ZIGBEE = 2'd1;
  localparam logic [1:0] KIND_THREAD = 2'd2;

  // what the back end does with one frame byte
  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_START,
    ACT_SEQ,
    ACT_PAN_LO,
    ACT_PAN_HI,
    ACT_MDST_LO,
    ACT_MDST_HI,
    ACT_MSRC_LO,
    ACT_MSRC_HI,
    ACT_THREAD,
    ACT_MESH,
    ACT_ZIGBEE,
    ACT_NSRC_LO,
    ACT_NSRC_HI,
    ACT_NDST_LO,
    ACT_NDST_HI,
    ACT_RADIUS,
    ACT_RELAYS,
    ACT_CMD
  } act_t;

  typedef struct packed {
    logic [7:0] data;
    act_t       act;
    logic       mdst_ext;
    logic       msrc_ext;
    logic       last;
  } tag_t;

  typedef struct packed {
    logic [2:0]  frame_type;
    logic [7:0]  sequence_number;
    logic [15:0] pan_identifier;
    logic [15:0] mac_source;
    logic [15:0] mac_destination;
    logic [1:0]  protocol_kind;
    logic [15:0] network_source;
    logic [15:0] network_destination;
    logic [7:0]  hop_radius;
    logic [7:0]  relay_total;
    logic [7:0]  network_command;
    logic        route_present;
  } res_t;

endpackage

// ===== rtl/core/mfp_fifo.sv =====
// ----------------------------------------------------------------------------
// mfp_fifo
// Small register FIFO with full/empty flags. DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module mfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wr_ptr;
  logic [AW:0]      rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (wr_ptr == rd_ptr);
  assign full    = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/mfp_front.sv =====
// ----------------------------------------------------------------------------
// mfp_front
// Byte front end: tracks position in the frame, works out the MAC header
// layout and payload layout, and tags each byte with the field it feeds.
// ----------------------------------------------------------------------------
module mfp_front
  import mfp_pkg::*;
#(
  parameter int MAX_ROUTE_HOPS = MAX_ROUTE_HOPS_DEF,
  parameter int MAX_FRAME_LEN  = MAX_FRAME_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] rx_byte,
  input  logic [6:0] frame_length,
  input  logic       first_byte,
  input  logic       tag_full,
  output logic       tag_push,
  output tag_t       tag
);

  localparam logic [1:0] AM_SHORT = 2'b10;
  localparam logic [1:0] AM_EXT   = 2'b11;
  localparam logic [2:0] FT_DATA  = 3'd1;

  typedef enum logic [2:0] {
    PL_IDLE = 3'b001,
    PL_MESH = 3'b010,
    PL_ZIG  = 3'b100
  } pl_state_t;

  // frame tracking
  logic [6:0] pos;
  logic [6:0] len_held;
  logic [7:0] fc_lo;
  logic [7:0] fc_hi;

  // header layout, latched at the sequence byte
  logic       has_pan;
  logic       dst_short;
  logic       src_short;
  logic [6:0] msrc_at;
  logic       pay;
  logic [6:0] pb;
  logic [6:0] plen;

  // payload layout
  pl_state_t  pl_state;
  logic       src_ok;
  logic [6:0] src_q;
  logic       dst_ok;
  logic [6:0] dst_q;
  logic       zig_cmd;
  logic       relay_ok;
  logic [6:0] relay_q;
  logic       cmd_ok;
  logic [6:0] cmd_q;

  logic       accept;
  logic [6:0] len_new;
  logic [6:0] p_eff;
  logic [6:0] len_eff;
  logic       live;
  logic [6:0] q;
  logic       in_pay;

  // header layout terms
  logic [1:0] dm;
  logic [1:0] sm;
  logic       dst_short_c;
  logic       dst_ext_c;
  logic [6:0] off1;
  logic [6:0] alen;
  logic [6:0] off2;
  logic       src_fit;
  logic [6:0] pb_c;

  // payload terms
  logic       is_thread;
  logic       is_mesh;
  logic       is_zig;
  logic [6:0] mo;
  logic       m_src_ok;
  logic [6:0] m_src_q;
  logic       m_dst_ok;
  logic [6:0] m_dst_q;
  logic [6:0] z_o1;
  logic [6:0] z_o2;
  logic [7:0] hops;
  logic [6:0] r_o3;
  logic [6:0] r_room;
  logic [6:0] r_steps;
  logic [6:0] r_cmd_q;

  assign accept   = push && !tag_full;
  assign len_new  = (8'(frame_length) > 8'(MAX_FRAME_LEN)) ? 7'd0 : frame_length;
  assign p_eff    = first_byte ? 7'd0 : pos;
  assign len_eff  = first_byte ? len_new : len_held;
  assign live     = (p_eff < len_eff);
  assign tag_push = accept && live;

  // MAC header layout from the frame control word
  assign dm          = fc_hi[3:2];
  assign sm          = fc_hi[7:6];
  assign dst_short_c = (dm == AM_SHORT) && (len_held >= 7'd7);
  assign dst_ext_c   = (dm == AM_EXT) && (len_held >= 7'd13);
  assign off1        = dst_short_c ? 7'd7 : (dst_ext_c ? 7'd13 : 7'd3);
  assign alen        = (sm == AM_SHORT) ? 7'd2 : 7'd8;
  // source PAN ID present unless compressed, skipped only if it fits
  assign off2        = (sm[1] && !fc_lo[6] && (off1 + 7'd2 <= len_held)) ? off1 + 7'd2 : off1;
  assign src_fit     = sm[1] && (off2 + alen <= len_held);
  assign pb_c        = src_fit ? off2 + alen : off2;

  // payload position
  assign in_pay = pay && (p_eff >= pb);
  assign q      = p_eff - pb;

  // payload classification on the first payload byte
  assign is_thread = (rx_byte[7:5] == 3'b011) || (rx_byte[7:6] == 2'b10);
  assign is_mesh   = (rx_byte[7:6] == 2'b10) && (plen >= 7'd5);
  assign is_zig    = !is_thread && (plen >= 7'd8) && !rx_byte[1];

  // mesh header: originator short or extended, then final
  always_comb begin
    if (!rx_byte[5]) begin
      m_src_ok = 1'b1;
      m_src_q  = 7'd1;
      mo       = 7'd3;
    end else if (plen >= 7'd9) begin
      m_src_ok = 1'b1;
      m_src_q  = 7'd7;
      mo       = 7'd9;
    end else begin
      m_src_ok = 1'b0;
      m_src_q  = 7'd1;
      mo       = 7'd1;
    end
    if (!rx_byte[4]) begin
      m_dst_ok = (mo + 7'd2 <= plen);
      m_dst_q  = mo;
    end else begin
      m_dst_ok = (mo + 7'd8 <= plen);
      m_dst_q  = mo + 7'd6;
    end
  end

  // Zigbee NWK: optional 64-bit dst/src, then source route
  assign z_o1 = (rx_byte[3] && (plen >= 7'd16)) ? 7'd16 : 7'd8;
  assign z_o2 = (rx_byte[4] && (z_o1 + 7'd8 <= plen)) ? z_o1 + 7'd8 : z_o1;

  // relay count clamp and the command byte after the relay list
  assign hops    = (rx_byte < 8'(MAX_ROUTE_HOPS)) ? rx_byte : 8'(MAX_ROUTE_HOPS);
  assign r_o3    = relay_q + 7'd2;
  assign r_room  = (plen - r_o3) >> 1;
  assign r_steps = (hops < {1'b0, r_room}) ? hops[6:0] : r_room;
  assign r_cmd_q = r_o3 + {r_steps[5:0], 1'b0};

  // tag selection
  always_comb begin
    tag          = '0;
    tag.data     = rx_byte;
    tag.act      = ACT_NONE;
    tag.last     = ((p_eff + 7'd1) == len_eff) && (len_eff >= 7'd3);
    if (p_eff == 7'd0) begin
      tag.act = ACT_START;
    end else if (p_eff == 7'd2) begin
      tag.act      = ACT_SEQ;
      tag.mdst_ext = dst_ext_c;
      tag.msrc_ext = src_fit && (sm == AM_EXT);
    end else if (p_eff == 7'd3 && has_pan) begin
      tag.act = ACT_PAN_LO;
    end else if (p_eff == 7'd4 && has_pan) begin
      tag.act = ACT_PAN_HI;
    end else if (p_eff == 7'd5 && dst_short) begin
      tag.act = ACT_MDST_LO;
    end else if (p_eff == 7'd6 && dst_short) begin
      tag.act = ACT_MDST_HI;
    end else if (src_short && p_eff == msrc_at) begin
      tag.act = ACT_MSRC_LO;
    end else if (src_short && p_eff == msrc_at + 7'd1) begin
      tag.act = ACT_MSRC_HI;
    end else if (in_pay) begin
      if (q == 7'd0) begin
        if (is_mesh) begin
          tag.act = ACT_MESH;
        end else if (is_thread) begin
          tag.act = ACT_THREAD;
        end else if (is_zig) begin
          tag.act = ACT_ZIGBEE;
        end
      end else begin
        case (pl_state)
          PL_MESH: begin
            if (src_ok && q == src_q) begin
              tag.act = ACT_NSRC_LO;
            end else if (src_ok && q == src_q + 7'd1) begin
              tag.act = ACT_NSRC_HI;
            end else if (dst_ok && q == dst_q) begin
              tag.act = ACT_NDST_LO;
            end else if (dst_ok && q == dst_q + 7'd1) begin
              tag.act = ACT_NDST_HI;
            end
          end
          PL_ZIG: begin
            if (q == 7'd2) begin
              tag.act = ACT_NDST_LO;
            end else if (q == 7'd3) begin
              tag.act = ACT_NDST_HI;
            end else if (q == 7'd4) begin
              tag.act = ACT_NSRC_LO;
            end else if (q == 7'd5) begin
              tag.act = ACT_NSRC_HI;
            end else if (q == 7'd6) begin
              tag.act = ACT_RADIUS;
            end else if (relay_ok && q == relay_q) begin
              tag.act  = ACT_RELAYS;
              tag.data = hops;
            end else if (cmd_ok && q == cmd_q) begin
              tag.act = ACT_CMD;
            end
          end
          default: begin
            tag.act = ACT_NONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      len_held <= '0;
      pl_state <= PL_IDLE;
    end else if (accept) begin
      if (first_byte) begin
        len_held <= len_new;
        pl_state <= PL_IDLE;
      end
      pos <= p_eff + {6'd0, live};
      if (live && p_eff == 7'd2) begin
        pl_state <= PL_IDLE;
      end else if (live && in_pay && q == 7'd0) begin
        if (is_mesh) begin
          pl_state <= PL_MESH;
        end else if (!is_thread && is_zig) begin
          pl_state <= PL_ZIG;
        end else begin
          pl_state <= PL_IDLE;
        end
      end
    end
  end

  // layout registers, no reset needed: all set before use in each frame
  always_ff @(posedge clk) begin
    if (accept && live) begin
      if (p_eff == 7'd0) begin
        fc_lo <= rx_byte;
      end
      if (p_eff == 7'd1) begin
        fc_hi <= rx_byte;
      end
      if (p_eff == 7'd2) begin
        has_pan   <= dst_short_c || dst_ext_c;
        dst_short <= dst_short_c;
        src_short <= src_fit && (sm == AM_SHORT);
        msrc_at   <= off2;
        pay       <= (pb_c < len_held) && (fc_lo[2:0] == FT_DATA);
        pb        <= pb_c;
        plen      <= len_held - pb_c;
      end
      if (in_pay && q == 7'd0) begin
        src_ok   <= m_src_ok;
        src_q    <= m_src_q;
        dst_ok   <= m_dst_ok;
        dst_q    <= m_dst_q;
        zig_cmd  <= (rx_byte[1:0] == 2'b01);
        relay_ok <= 1'b0;
        cmd_ok   <= 1'b0;
      end
      if (in_pay && pl_state == PL_ZIG && q == 7'd1) begin
        relay_ok <= rx_byte[2] && (z_o2 + 7'd2 <= plen);
        relay_q  <= z_o2;
        cmd_ok   <= zig_cmd && !(rx_byte[2] && (z_o2 + 7'd2 <= plen)) && (z_o2 < plen);
        cmd_q    <= z_o2;
      end
      if (in_pay && pl_state == PL_ZIG && relay_ok && q == relay_q && q != 7'd1) begin
        cmd_ok <= zig_cmd && (r_cmd_q < plen);
        cmd_q  <= r_cmd_q;
      end
    end
  end

endmodule

// ===== rtl/core/mfp_back.sv =====
// ----------------------------------------------------------------------------
// mfp_back
// Field back end: applies tagged bytes to the result fields and hands the
// finished result to the result queue on the last byte of a frame.
// ----------------------------------------------------------------------------
module mfp_back
  import mfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic tag_valid,
  input  tag_t tag,
  output logic tag_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  res_t fld;
  res_t fld_next;

  // a last byte waits until the result queue has room
  assign tag_pop  = tag_valid && (!tag.last || !res_full);
  assign res_push = tag_pop && tag.last && !rst;
  assign res      = fld_next;

  always_comb begin
    fld_next = fld;
    case (tag.act)
      ACT_START: begin
        fld_next                     = '0;
        fld_next.frame_type          = tag.data[2:0];
        fld_next.pan_identifier      = ADDR_ABSENT;
        fld_next.mac_source          = ADDR_ABSENT;
        fld_next.mac_destination     = ADDR_ABSENT;
        fld_next.protocol_kind       = KIND_PLAIN;
      end
      ACT_SEQ: begin
        fld_next.sequence_number = tag.data;
        if (tag.mdst_ext) begin
          fld_next.mac_destination = ADDR_EXTENDED;
        end
        if (tag.msrc_ext) begin
          fld_next.mac_source = ADDR_EXTENDED;
        end
      end
      ACT_PAN_LO:  fld_next.pan_identifier[7:0]       = tag.data;
      ACT_PAN_HI:  fld_next.pan_identifier[15:8]      = tag.data;
      ACT_MDST_LO: fld_next.mac_destination[7:0]      = tag.data;
      ACT_MDST_HI: fld_next.mac_destination[15:8]     = tag.data;
      ACT_MSRC_LO: fld_next.mac_source[7:0]           = tag.data;
      ACT_MSRC_HI: fld_next.mac_source[15:8]          = tag.data;
      ACT_THREAD: begin
        // no mesh header: network addresses repeat the MAC ones
        fld_next.protocol_kind       = KIND_THREAD;
        fld_next.network_source      = fld.mac_source;
        fld_next.network_destination = fld.mac_destination;
      end
      ACT_MESH: begin
        fld_next.protocol_kind = KIND_THREAD;
        fld_next.route_present = 1'b1;
      end
      ACT_ZIGBEE: begin
        fld_next.protocol_kind = KIND_ZIGBEE;
        fld_next.route_present = 1'b1;
      end
      ACT_NSRC_LO: fld_next.network_source[7:0]       = tag.data;
      ACT_NSRC_HI: fld_next.network_source[15:8]      = tag.data;
      ACT_NDST_LO: fld_next.network_destination[7:0]  = tag.data;
      ACT_NDST_HI: fld_next.network_destination[15:8] = tag.data;
      ACT_RADIUS:  fld_next.hop_radius                = tag.data;
      ACT_RELAYS:  fld_next.relay_total               = tag.data;
      ACT_CMD:     fld_next.network_command           = tag.data;
      default: begin
        fld_next = fld;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tag_pop) begin
      fld <= fld_next;
    end
  end

endmodule

// ===== rtl/core/ieee802154_mac_frame_parser.sv =====
// ----------------------------------------------------------------------------
// ieee802154_mac_frame_parser
// 802.15.4 MAC header parser with Zigbee NWK and 6LoWPAN mesh decode.
// ----------------------------------------------------------------------------
// One received frame byte (FCS removed) is pushed per word, carrying the
// frame length on every byte and first_byte on the first. The block takes
// one byte per clock while full is low: the front end tags each byte with
// the field it feeds (MAC header layout is known once the frame control word
// and length are in, payload layout once the first mesh byte or the NWK
// frame control word is in), a TAG_QUEUE_DEPTH deep queue carries the tags,
// and the back end fills the result fields one byte per clock unless a
// last byte waits for room in the result queue. On the last byte of a
// frame of 3 or more bytes one result word is written to a
// RESULT_QUEUE_DEPTH deep output queue, whose head drives the result ports.
// Frames shorter than 3 bytes, or with a length above MAX_FRAME_LEN, yield
// nothing. A first_byte always restarts, dropping an unfinished frame; bytes
// past the frame length are ignored. PAN ID and MAC addresses read 0xFFFF
// when absent, MAC addresses 0xFFFE when extended. full goes high only when
// the output side has been stalled long enough to fill both queues.
// ----------------------------------------------------------------------------
module ieee802154_mac_frame_parser
  import mfp_pkg::*;
#(
  parameter int MAX_ROUTE_HOPS     = MAX_ROUTE_HOPS_DEF,
  parameter int MAX_FRAME_LEN      = MAX_FRAME_LEN_DEF,
  parameter int TAG_QUEUE_DEPTH    = TAG_QUEUE_DEPTH_DEF,    // power of two
  parameter int RESULT_QUEUE_DEPTH = RESULT_QUEUE_DEPTH_DEF  // power of two
) (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  input  logic [6:0]  frame_length,
  input  logic        first_byte,
  // result output
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  frame_type,
  output logic [7:0]  sequence_number,
  output logic [15:0] pan_identifier,
  output logic [15:0] mac_source,
  output logic [15:0] mac_destination,
  output logic [1:0]  protocol_kind,
  output logic [15:0] network_source,
  output logic [15:0] network_destination,
  output logic [7:0]  hop_radius,
  output logic [7:0]  relay_total,
  output logic [7:0]  network_command,
  output logic        route_present
);

  tag_t tag_in;
  tag_t tag_out;
  logic tag_push;
  logic tag_full;
  logic tag_empty;
  logic tag_pop;
  res_t res_in;
  res_t res_out;
  logic res_push;
  logic res_full;

  // front end: byte position and field tagging
  mfp_front #(
    .MAX_ROUTE_HOPS (MAX_ROUTE_HOPS),
    .MAX_FRAME_LEN  (MAX_FRAME_LEN)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .rx_byte      (rx_byte),
    .frame_length (frame_length),
    .first_byte   (first_byte),
    .tag_full     (tag_full),
    .tag_push     (tag_push),
    .tag          (tag_in)
  );

  // decoupling queue between front and back
  mfp_fifo #(
    .WIDTH ($bits(tag_t)),
    .DEPTH (TAG_QUEUE_DEPTH)
  ) u_tag_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (tag_push),
    .wdata (tag_in),
    .full  (tag_full),
    .pop   (tag_pop),
    .rdata (tag_out),
    .empty (tag_empty)
  );

  // back end: result field assembly
  mfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tag_valid (!tag_empty),
    .tag       (tag_out),
    .tag_pop   (tag_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // finished results wait here for the consumer
  mfp_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RESULT_QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  // the input side stalls only when the tag queue is full
  assign full = tag_full;

  assign frame_type          = res_out.frame_type;
  assign sequence_number     = res_out.sequence_number;
  assign pan_identifier      = res_out.pan_identifier;
  assign mac_source          = res_out.mac_source;
  assign mac_destination     = res_out.mac_destination;
  assign protocol_kind       = res_out.protocol_kind;
  assign network_source      = res_out.network_source;
  assign network_destination = res_out.network_destination;
  assign hop_radius          = res_out.hop_radius;
  assign relay_total         = res_out.relay_total;
  assign network_command     = res_out.network_command;
  assign route_present       = res_out.route_present;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 802.15.4 MAC frame parser. Frame bytes go in
// one word at a time, and a local decoder predicts the parsed header of each
// completed frame. Every popped result word is then checked field by field.
// ----------------------------------------------------------------------------
module tb_top
  import mfp_pkg::*;
();

  // --------------------------------------------------------------------------
  // bench constants
  // --------------------------------------------------------------------------
  localparam int MAX_FRAME_BYTES = MAX_FRAME_LEN_DEF;
  localparam int MAX_HOPS        = MAX_ROUTE_HOPS_DEF;
  localparam int LEN_FIELD_MAX   = 125;    // largest length the radio reports
  localparam int RANDOM_BYTES    = 1850;   // stored bytes in the random part
  localparam int HOLDOFF_CYCLES  = 400;    // long receiver stall
  localparam int END_SETTLE      = 10;     // settle time after the last result
  localparam int QUIET_LIMIT     = 4000;   // cycles with no handshake at all

  // MAC frame control codes
  localparam logic [2:0] FT_BEACON = 3'd0;
  localparam logic [2:0] FT_DATA   = 3'd1;
  localparam logic [1:0] AM_SHORT  = 2'd2;
  localparam logic [1:0] AM_EXT    = 2'd3;
  // first payload byte dispatch patterns
  localparam logic [7:0] IPHC_MASK     = 8'hE0;
  localparam logic [7:0] IPHC_DISPATCH = 8'h60;
  localparam logic [7:0] MESH_MASK     = 8'hC0;
  localparam logic [7:0] MESH_DISPATCH = 8'h80;
  // Zigbee NWK frame control
  localparam logic [1:0] NWK_FT_DATA = 2'd0;
  localparam logic [1:0] NWK_FT_CMD  = 2'd1;

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  rx_byte;
  logic [6:0]  frame_length;
  logic        first_byte;
  logic        empty;
  logic        pop;
  logic [2:0]  frame_type;
  logic [7:0]  sequence_number;
  logic [15:0] pan_identifier;
  logic [15:0] mac_source;
  logic [15:0] mac_destination;
  logic [1:0]  protocol_kind;
  logic [15:0] network_source;
  logic [15:0] network_destination;
  logic [7:0]  hop_radius;
  logic [7:0]  relay_total;
  logic [7:0]  network_command;
  logic        route_present;

  ieee802154_mac_frame_parser dut (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .full                (full),
    .rx_byte             (rx_byte),
    .frame_length        (frame_length),
    .first_byte          (first_byte),
    .empty               (empty),
    .pop                 (pop),
    .frame_type          (frame_type),
    .sequence_number     (sequence_number),
    .pan_identifier      (pan_identifier),
    .mac_source          (mac_source),
    .mac_destination     (mac_destination),
    .protocol_kind       (protocol_kind),
    .network_source      (network_source),
    .network_destination (network_destination),
    .hop_radius          (hop_radius),
    .relay_total         (relay_total),
    .network_command     (network_command),
    .route_present       (route_present)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // shared bench state
  // --------------------------------------------------------------------------
  res_t       pending_results[$];   // parsed headers still owed by the DUT
  logic [7:0] frame_buf[$];         // bytes of the frame being built
  int         mismatches   = 0;
  int         stored_bytes = 0;     // bytes that land inside a frame
  bit         tx_idle_on   = 1'b1;
  bit         rx_idle_on   = 1'b1;
  int         hold_req     = 0;     // receiver picks this up and stalls

  // decoder copy of the frame assembly state
  logic [7:0] frame_store [0:MAX_FRAME_BYTES-1];
  int         fill_pos = 0;
  int         fill_len = 0;

  // --------------------------------------------------------------------------
  // header decoder: what the block should report for a completed frame
  // --------------------------------------------------------------------------
  function automatic logic [15:0] word_at(input int at);
    return {frame_store[at + 1], frame_store[at]};
  endfunction

  function automatic res_t decode_header(input int len);
    res_t        r;
    logic [15:0] fc;
    logic [15:0] nfc;
    logic [7:0]  d;
    int          off;
    int          pb;
    int          plen;
    int          o;
    int          alen;
    int          hops;
    fc = word_at(0);
    r = '0;
    r.frame_type      = fc[2:0];
    r.sequence_number = frame_store[2];
    r.pan_identifier  = ADDR_ABSENT;
    r.mac_source      = ADDR_ABSENT;
    r.mac_destination = ADDR_ABSENT;
    off = 3;

    // destination PAN + address, only if it fits
    if (fc[11:10] == AM_SHORT && off + 4 <= len) begin
      r.pan_identifier  = word_at(off);
      r.mac_destination = word_at(off + 2);
      off += 4;
    end else if (fc[11:10] == AM_EXT && off + 10 <= len) begin
      r.pan_identifier  = word_at(off);
      r.mac_destination = ADDR_EXTENDED;
      off += 10;
    end

    // source PAN is skipped unless compressed away
    if (fc[15:14] == AM_SHORT || fc[15:14] == AM_EXT) begin
      alen = (fc[15:14] == AM_SHORT) ? 2 : 8;
      if (!fc[6] && off + 2 <= len) off += 2;
      if (off + alen <= len) begin
        r.mac_source = (fc[15:14] == AM_SHORT) ? word_at(off) : ADDR_EXTENDED;
        off += alen;
      end
    end

    if (off < len && r.frame_type == FT_DATA) begin
      pb   = off;
      plen = len - off;
      d    = frame_store[pb];
      if ((d & IPHC_MASK) == IPHC_DISPATCH || (d & MESH_MASK) == MESH_DISPATCH) begin
        r.protocol_kind = KIND_THREAD;
        if ((d & MESH_MASK) == MESH_DISPATCH && plen >= 5) begin
          // mesh header: bit 5 long originator, bit 4 long final
          o = 1;
          if (!d[5] && o + 2 <= plen) begin
            r.network_source = word_at(pb + o);
            o += 2;
          end else if (d[5] && o + 8 <= plen) begin
            r.network_source = word_at(pb + o + 6);
            o += 8;
          end
          if (!d[4] && o + 2 <= plen)
            r.network_destination = word_at(pb + o);
          else if (d[4] && o + 8 <= plen)
            r.network_destination = word_at(pb + o + 6);
          r.route_present = 1'b1;
        end else begin
          r.network_source      = r.mac_source;
          r.network_destination = r.mac_destination;
        end
      end else if (plen >= 8 && d[1:0] <= NWK_FT_CMD) begin
        nfc = word_at(pb);
        o   = 8;
        r.protocol_kind       = KIND_ZIGBEE;
        r.network_destination = word_at(pb + 2);
        r.network_source      = word_at(pb + 4);
        r.hop_radius          = frame_store[pb + 6];
        if (nfc[11] && o + 8 <= plen) o += 8;   // extended destination
        if (nfc[12] && o + 8 <= plen) o += 8;   // extended source
        if (nfc[10] && o + 2 <= plen) begin     // source route subframe
          hops = frame_store[pb + o];
          if (hops > MAX_HOPS) hops = MAX_HOPS;
          o += 2;
          for (int i = 0; i < hops && o + 2 <= plen; i++) o += 2;
          r.relay_total = hops[7:0];
        end
        r.route_present = 1'b1;
        if (nfc[1:0] == NWK_FT_CMD && o < plen) r.network_command = frame_store[pb + o];
      end
    end
    return r;
  endfunction

  // frame assembly for one accepted word; queues a result at the last byte
  function automatic void predict_byte(input logic [7:0] b, input logic [6:0] flen,
                                       input logic starts);
    if (starts) begin
      fill_pos = 0;
      fill_len = (flen > MAX_FRAME_BYTES) ? 0 : flen;
    end
    if (fill_pos >= fill_len) return;
    frame_store[fill_pos] = b;
    fill_pos++;
    stored_bytes++;
    if (fill_pos < fill_len || fill_len < 3) return;
    pending_results.push_back(decode_header(fill_len));
  endfunction

  // --------------------------------------------------------------------------
  // idle lengths: mostly none or short, now and then long
  // --------------------------------------------------------------------------
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  // Called at a rising edge. push stays high when the next word follows
  // right away, so it is never lowered and raised in one step.
  task automatic send_byte(input logic [7:0] b, input logic [6:0] flen,
                           input logic starts);
    int gap;
    push         <= 1'b1;
    rx_byte      <= b;
    frame_length <= flen;
    first_byte   <= starts;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_byte(b, flen, starts);
    gap = tx_idle_on ? idle_length() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // send count words of frame_buf under length flen; past the buffer, noise
  task automatic send_frame(input int flen, input int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = (i < frame_buf.size()) ? frame_buf[i] : 8'($urandom());
      send_byte(b, 7'(flen), i == 0);
    end
  endtask

  // sender rests until every owed result is out
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // frame builder
  // --------------------------------------------------------------------------
  task automatic put16(input logic [15:0] v);
    frame_buf.push_back(v[7:0]);
    frame_buf.push_back(v[15:8]);
  endtask

  task automatic put_noise(input int n);
    for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom()));
  endtask

  // A well formed frame with random content: mostly data frames whose
  // payload opens with IPHC, a mesh header, or a Zigbee NWK header.
  task automatic make_frame(output int flen);
    logic [15:0] fc;
    logic [15:0] nfc;
    logic [7:0]  d;
    int          pick;
    int          hops;
    frame_buf.delete();
    fc = 16'($urandom());
    if ($urandom_range(0, 99) < 70) fc[2:0] = FT_DATA;
    put16(fc);
    put_noise(1);                                   // sequence number
    if (fc[11:10] == AM_SHORT) put_noise(4);
    else if (fc[11:10] == AM_EXT) put_noise(10);
    if (fc[15:14] == AM_SHORT || fc[15:14] == AM_EXT) begin
      if (!fc[6]) put_noise(2);
      put_noise((fc[15:14] == AM_SHORT) ? 2 : 8);
    end

    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      frame_buf.push_back({3'b011, 5'($urandom())});
    end else if (pick < 45) begin
      d = {2'b10, 6'($urandom())};
      frame_buf.push_back(d);
      put_noise(d[5] ? 8 : 2);
      put_noise(d[4] ? 8 : 2);
    end else if (pick < 85) begin
      nfc = 16'($urandom());
      nfc[1:0] = $urandom_range(0, 1) ? NWK_FT_CMD : NWK_FT_DATA;
      // keep the first byte clear of the 6LoWPAN dispatch ranges
      if (nfc[7:6] == 2'b10) nfc[7:6] = 2'b00;
      if (nfc[7:5] == 3'b011) nfc[5] = 1'b0;
      put16(nfc);
      put_noise(6);                                 // dst, src, radius, seq
      if (nfc[11]) put_noise(8);
      if (nfc[12]) put_noise(8);
      if (nfc[10]) begin
        hops = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        frame_buf.push_back(8'(hops));
        put_noise(1);                               // relay index
        put_noise(2 * ((hops > 10) ? 10 : hops));
      end
      if (nfc[1:0] == NWK_FT_CMD) put_noise(1);
    end
    put_noise(($urandom_range(0, 39) == 0) ? $urandom_range(40, 110) : $urandom_range(0, 6));

    while (frame_buf.size() > LEN_FIELD_MAX) void'(frame_buf.pop_back());
    flen = frame_buf.size();
    // cut some frames short so headers run off the end
    if ($urandom_range(0, 9) == 0) flen = $urandom_range(3, flen);
  endtask

  // --------------------------------------------------------------------------
  // result side: pops at random, checks each result word against the oldest
  // prediction
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin : result_checker
    res_t want;
    int   stall_left;
    int   hold_left;
    int   gap;
    stall_left = 0;
    hold_left  = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result word popped with none expected");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("frame_type",          16'(want.frame_type),      16'(frame_type));
          check_field("sequence_number",     16'(want.sequence_number), 16'(sequence_number));
          check_field("pan_identifier",      want.pan_identifier,       pan_identifier);
          check_field("mac_source",          want.mac_source,           mac_source);
          check_field("mac_destination",     want.mac_destination,      mac_destination);
          check_field("protocol_kind",       16'(want.protocol_kind),   16'(protocol_kind));
          check_field("network_source",      want.network_source,       network_source);
          check_field("network_destination", want.network_destination, network_destination);
          check_field("hop_radius",          16'(want.hop_radius),      16'(hop_radius));
          check_field("relay_total",         16'(want.relay_total),     16'(relay_total));
          check_field("network_command",     16'(want.network_command), 16'(network_command));
          check_field("route_present",       16'(want.route_present),   16'(route_present));
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        gap = rx_idle_on ? idle_length() : 0;
        stall_left = (gap > 0) ? gap - 1 : 0;
        pop <= (gap == 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: any handshake on either side counts as progress
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // words before any frame, and frames too short to yield a result
  task automatic test_stray_bytes();
    send_byte(8'h00, 7'd0, 1'b0);
    send_byte(8'hFF, 7'(LEN_FIELD_MAX), 1'b0);
    send_byte(8'hA5, 7'd0, 1'b1);        // zero length: nothing stored
    send_byte(8'h5A, 7'd0, 1'b0);
    send_byte(8'hFF, 7'd1, 1'b1);
    send_byte(8'h12, 7'd2, 1'b1);
    send_byte(8'h34, 7'd2, 1'b0);
  endtask

  // minimum frames, overrun, restart mid frame, and a small Thread data frame
  task automatic test_short_frames();
    // all ones: raw type 7, both modes extended but nothing fits
    repeat (3) send_byte(8'hFF, 7'd3, 1'b0);  // ignored, previous frame is done
    send_byte(8'hFF, 7'd3, 1'b1);
    send_byte(8'hFF, 7'd3, 1'b0);
    send_byte(8'hFF, 7'd3, 1'b0);
    send_byte(8'h77, 7'd3, 1'b0);        // past the end: ignored
    // abandoned frame, then a beacon of zeros
    send_byte(8'h41, 7'd20, 1'b1);
    send_byte(8'h88, 7'd20, 1'b0);
    send_byte({5'd0, FT_BEACON}, 7'd3, 1'b1);
    send_byte(8'h00, 7'd3, 1'b0);
    send_byte(8'h00, 7'd3, 1'b0);
    // data, PAN compressed, short/short, IPHC payload
    frame_buf = '{8'h41, 8'h88, 8'h9C, 8'hCD, 8'hAB, 8'h34, 8'h12, 8'h78, 8'h56, 8'h7A};
    send_frame(10, 10);
  endtask

  // receiver stalls for a long stretch while three-byte frames keep coming,
  // so both queues fill and full pushes back; then everything drains
  task automatic test_receiver_holdoff();
    tx_idle_on = 1'b0;
    hold_req   = HOLDOFF_CYCLES;
    for (int n = 0; n < 40; n++) begin
      frame_buf.delete();
      put_noise(3);
      send_frame(3, 3);
    end
    wait_drained();
    tx_idle_on = 1'b1;
  endtask

  // bulk traffic: mostly well formed frames, some restarts, overruns and
  // short length words; idling is redrawn at random every 16 frames
  task automatic test_random_traffic();
    int start;
    int flen;
    int mode;
    int frames;
    start  = stored_bytes;
    frames = 0;
    while (stored_bytes - start < RANDOM_BYTES) begin
      if (frames % 16 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 2) == 0) wait_drained();
      end
      frames++;
      mode = $urandom_range(0, 99);
      if (mode < 4) begin
        frame_buf.delete();
        flen = $urandom_range(0, 2);
        send_frame(flen, flen + $urandom_range(0, 2));
      end else begin
        make_frame(flen);
        if (mode < 11 && flen > 1)
          send_frame(flen, $urandom_range(1, flen - 1));      // dropped by restart
        else if (mode < 19)
          send_frame(flen, flen + $urandom_range(1, 3));      // trailing junk
        else
          send_frame(flen, flen);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    push         <= 1'b0;
    rx_byte      <= 8'h00;
    frame_length <= 7'd0;
    first_byte   <= 1'b0;
    rst          <= 1'b1;
    for (int i = 0; i < MAX_FRAME_BYTES; i++) frame_store[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_stray_bytes();
    test_short_frames();
    test_receiver_holdoff();
    test_random_traffic();

    rx_idle_on = 1'b1;
    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
